FILE: hdl/target_heading_angle_macros.svh
// Assertion macros shared by the heading angle block.
`ifndef TARGET_HEADING_ANGLE_MACROS_SVH
`define TARGET_HEADING_ANGLE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define THA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define THA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tha_pkg.sv
// Types, constants and elaboration-time table builders for the heading angle block.
package tha_pkg;

    localparam int FIELD_W        = 10;
    localparam int ANGLE_W        = 16;
    localparam int MAG_W          = 15;
    localparam int CFG_IDX_W      = 2;
    localparam int COORD_BITS_DEF = 10;

    localparam logic [CFG_IDX_W-1:0] REG_CAR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_Y = 2'd1;

    localparam logic [FIELD_W-1:0] CAR_X_RST = 10'd160;
    localparam logic [FIELD_W-1:0] CAR_Y_RST = 10'd239;

    // sign codes: zero, positive, negative
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam int DP_W         = 64;
    localparam int CORDIC_STEPS = 60;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int RAD_FRAC     = 60;
    localparam int DEG_FRAC     = 56;
    localparam int OUT_FRAC     = 8;
    localparam int OUT_SHIFT    = DEG_FRAC - OUT_FRAC;
    localparam int SCALE_TOP    = 58;

    localparam logic [DP_W-1:0] DEG45_FX = 64'd45 << DEG_FRAC;
    localparam logic [DP_W-1:0] DEG50_FX = 64'd50 << DEG_FRAC;

    typedef logic [CORDIC_STEPS-1:0][DP_W-1:0] angle_tab_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // 64 by 64 restoring division, elaboration only
    function automatic logic [DP_W-1:0] udiv_f(input logic [DP_W-1:0] n,
                                               input logic [DP_W-1:0] d);
        logic [DP_W:0]   r;
        logic [DP_W-1:0] q;
        r = '0;
        q = '0;
        for (int k = DP_W - 1; k >= 0; k--)
        begin
            r = {r[DP_W-1:0], n[k]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(a*b/c), low 64 bits of the quotient
    function automatic logic [DP_W-1:0] mul_div_f(input logic [DP_W-1:0] a,
                                                  input logic [DP_W-1:0] b,
                                                  input logic [DP_W-1:0] c);
        logic [2*DP_W-1:0] p;
        logic [DP_W:0]     r;
        logic [DP_W-1:0]   q;
        p = {{DP_W{1'b0}}, a} * {{DP_W{1'b0}}, b};
        r = '0;
        q = '0;
        for (int k = 2 * DP_W - 1; k >= 0; k--)
        begin
            r = {r[DP_W-1:0], p[k]};
            q = {q[DP_W-2:0], 1'b0};
            if (r >= {1'b0, c})
            begin
                r    = r - {1'b0, c};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q60 radians by the alternating series
    function automatic logic [DP_W-1:0] atan_recip_f(input logic [DP_W-1:0] m);
        logic [DP_W-1:0] term;
        logic [DP_W-1:0] sum;
        logic [DP_W-1:0] dterm;
        logic [DP_W-1:0] k;
        logic            sub;
        term = udiv_f(64'd1 << RAD_FRAC, m);
        sum  = term;
        k    = 64'd1;
        sub  = 1'b1;
        for (int j = 0; j < DP_W; j++)
        begin
            if (term != '0)
            begin
                term  = udiv_f(udiv_f(term, m), m);
                dterm = udiv_f(term, 2 * k + 1);
                sum   = sub ? sum - dterm : sum + dterm;
                sub   = !sub;
                k     = k + 1;
            end
        end
        return sum;
    endfunction

    // micro-angles in Q56 degrees
    function automatic angle_tab_t build_angle_tab();
        angle_tab_t      tab;
        logic [DP_W-1:0] quarter_pi;
        quarter_pi = 4 * atan_recip_f(64'd5) - atan_recip_f(64'd239);
        tab[0]     = DEG45_FX;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            tab[i] = mul_div_f(atan_recip_f(64'd1 << i), DEG45_FX, quarter_pi);
        end
        return tab;
    endfunction

    localparam angle_tab_t STEP_ANGLE = build_angle_tab();

    // shift right, truncating toward zero
    function automatic logic signed [DP_W-1:0] tz_shift(input logic signed [DP_W-1:0] v,
                                                        input logic [STEP_W-1:0] s);
        logic signed [DP_W-1:0] bias;
        bias = (64'sd1 <<< s) - 64'sd1;
        return v[DP_W-1] ? ((v + bias) >>> s) : (v >>> s);
    endfunction

endpackage

FILE: hdl/tha_ifs.sv
// Valid/ready channel interfaces for target points, angles and register writes.
interface tha_target_if import tha_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] target_x;
    logic [FIELD_W-1:0] target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface tha_angle_if import tha_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_q8;

    modport source (output valid, output angle_q8, input ready);
    modport sink   (input valid, input angle_q8, output ready);
endinterface

interface tha_cfg_if import tha_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/target_heading_angle.sv
// Top level of the heading angle block: registers, sequencer, rounding and output stage.
// Heading angle from the configured car position (car_x, car_y) to a target pixel,
// as signed Q8 degrees. A target on the car column gives 0 and a target on the car
// row gives +-50 (or +-25), both without the CORDIC. Any other target runs a 60-step
// vectoring CORDIC, one micro-rotation a cycle, reusing one set of add/shift logic for
// every step. The block takes one item at a time: target.ready is high only while the
// sequencer is idle. The result waits in an output register, so a new item may be taken
// before it is read. Register writes are taken at any time and must only be made while
// the block is idle.
`include "target_heading_angle_macros.svh"

module target_heading_angle import tha_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tha_target_if.sink     target,
    tha_angle_if.source    angle,
    tha_cfg_if.sink        cfg
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CORDIC = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;

    localparam logic [FIELD_W-1:0] COORD_MASK =
        (COORD_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << COORD_BITS) - 1);
    localparam logic [DP_W-1:0] HALF_LSB   = 64'd1 << (OUT_SHIFT - 1);
    localparam logic [DP_W-1:0] HALF_LSB_H = 64'd1 << OUT_SHIFT;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

    logic [1:0]                 state_reg, state_next;
    logic [FIELD_W-1:0]         car_x_reg, car_y_reg;
    logic [1:0]                 last_sign_reg, last_sign_next;
    logic [1:0]                 sign_reg, sign_next;
    logic                       halve_reg, halve_next;
    logic [DP_W-1:0]            mag_reg, mag_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [ANGLE_W-1:0]  angle_reg, angle_next;

    logic                       in_beat;
    logic                       out_beat;
    logic                       out_free;
    logic [FIELD_W-1:0]         tx, ty, cx, cy;
    logic signed [FIELD_W:0]    dx, dy;
    logic signed [FIELD_W:0]    adx, ady;
    logic                       dx_zero, dy_zero;
    logic [1:0]                 new_sign;
    logic                       new_halve;
    logic                       cordic_start;
    cordic_stat_t               cstat;
    logic [DP_W-1:0]            cordic_mag;
    logic [DP_W-1:0]            rnd_sum;
    logic [MAG_W-1:0]           q_mag;
    logic signed [ANGLE_W-1:0]  q_signed;
    logic                       seq_idle;
    logic                       in_cordic;
    logic                       angle_in_range;

    assign in_beat  = target.valid && target.ready;
    assign out_beat = angle.valid && angle.ready;
    assign out_free = !out_valid_reg || angle.ready;

    assign target.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign angle.valid  = out_valid_reg;
    assign angle.angle_q8 = angle_reg;

    // register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_x_reg <= CAR_X_RST;
            car_y_reg <= CAR_Y_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CAR_X: car_x_reg <= cfg.data;
                REG_CAR_Y: car_y_reg <= cfg.data;
                default:   ;
            endcase
        end
    end

    assign tx = target.target_x & COORD_MASK;
    assign ty = target.target_y & COORD_MASK;
    assign cx = car_x_reg & COORD_MASK;
    assign cy = car_y_reg & COORD_MASK;

    assign dx  = signed'({1'b0, tx}) - signed'({1'b0, cx});
    assign dy  = signed'({1'b0, cy}) - signed'({1'b0, ty});
    assign adx = dx[FIELD_W] ? -dx : dx;
    assign ady = dy[FIELD_W] ? -dy : dy;
    assign dx_zero = (dx == '0);
    assign dy_zero = (dy == '0);

    always_comb
    begin
        if (dx_zero)
            new_sign = SIGN_ZERO;
        else if (dy_zero)
            new_sign = dx[FIELD_W] ? SIGN_NEG : SIGN_POS;
        else
            new_sign = (dx[FIELD_W] != dy[FIELD_W]) ? SIGN_NEG : SIGN_POS;
    end

    // halve when the sign flips between two nonzero angles
    assign new_halve = (new_sign != SIGN_ZERO) && (last_sign_reg != SIGN_ZERO)
                       && (new_sign != last_sign_reg);

    assign cordic_start = in_beat && !dx_zero && !dy_zero;

    tha_cordic #(
        .COORD_BITS (COORD_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .num   (adx[FIELD_W-1:0]),
        .den   (ady[FIELD_W-1:0]),
        .stat  (cstat),
        .mag   (cordic_mag)
    );

    // round half away from zero on the magnitude, then apply the sign
    assign rnd_sum  = mag_reg + (halve_reg ? HALF_LSB_H : HALF_LSB);
    assign q_mag    = halve_reg ? rnd_sum[OUT_SHIFT+MAG_W:OUT_SHIFT+1]
                                : rnd_sum[OUT_SHIFT+MAG_W-1:OUT_SHIFT];
    assign q_signed = (sign_reg == SIGN_NEG) ? -signed'({1'b0, q_mag})
                                             : signed'({1'b0, q_mag});

    always_comb
    begin
        state_next     = state_reg;
        last_sign_next = last_sign_reg;
        sign_next      = sign_reg;
        halve_next     = halve_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        angle_next     = angle_reg;
        if (out_beat)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    last_sign_next = new_sign;
                    sign_next      = new_sign;
                    halve_next     = new_halve;
                    if (dx_zero)
                    begin
                        mag_next   = '0;
                        state_next = ST_ROUND;
                    end
                    else if (dy_zero)
                    begin
                        mag_next   = DEG50_FX;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        state_next = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cstat.done)
                begin
                    mag_next   = cordic_mag;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    angle_next     = q_signed;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_sign_reg <= SIGN_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_sign_reg <= last_sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        halve_reg <= halve_next;
        mag_reg   <= mag_next;
        angle_reg <= angle_next;
    end

    assign seq_idle       = (state_reg == ST_IDLE);
    assign in_cordic      = (state_reg == ST_CORDIC);
    assign angle_in_range = (angle_reg <= ANGLE_LIMIT) && (angle_reg >= -ANGLE_LIMIT);

    `THA_ASSERT_NOW(a_done_in_cordic, cstat.done, in_cordic, "CORDIC done outside its state")
    `THA_ASSERT_NEXT(a_accept_leaves_idle, in_beat, !seq_idle, "idle after a beat")
    `THA_ASSERT_NOW(a_angle_range, out_valid_reg, angle_in_range, "angle out of range")
    `THA_ASSERT_NOW(a_busy_matches_state, cstat.busy, in_cordic, "CORDIC busy outside state")

endmodule

FILE: hdl/tha_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle accumulated in Q56 degrees.
module tha_cordic import tha_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FIELD_W-1:0] num,
    input  logic [FIELD_W-1:0] den,
    output cordic_stat_t       stat,
    output logic [DP_W-1:0]    mag
);

    localparam int SCALE_SHIFT = SCALE_TOP - COORD_BITS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [DP_W-1:0] x_reg, x_next;
    logic signed [DP_W-1:0] y_reg, y_next;
    logic signed [DP_W-1:0] z_reg, z_next;
    logic [STEP_W-1:0]      iter_reg, iter_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;
    logic signed [DP_W-1:0] ang;

    assign xs  = tz_shift(x_reg, iter_reg);
    assign ys  = tz_shift(y_reg, iter_reg);
    assign ang = signed'(STEP_ANGLE[iter_reg]);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = signed'(DP_W'(den) << SCALE_SHIFT);
            y_next    = signed'(DP_W'(num) << SCALE_SHIFT);
            z_next    = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // rotate toward the x axis
            if (!y_reg[DP_W-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign mag       = z_reg[DP_W-1] ? '0 : DP_W'(z_reg);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for target_heading_angle: heading predictor, bursty driver, checker.
`timescale 1ns / 1ps

module tb;
    import tha_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int                   NUM_PHASES   = 10;
    localparam int                   RANDOM_PER_PHASE = 88;
    localparam int                   HOLD_OFF_CYCLES  = 600;
    localparam int                   DRAIN_CYCLES     = 80;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
    } target_pt_t;

    logic clk = 1'b0;
    logic rst_n;

    tha_target_if target_ch();
    tha_angle_if  angle_ch();
    tha_cfg_if    cfg_ch();

    target_heading_angle i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .target (target_ch),
        .angle  (angle_ch),
        .cfg    (cfg_ch)
    );

    // heading model state
    logic [63:0]        micro_deg [CORDIC_STEPS];
    logic [FIELD_W-1:0] car_x_m;
    logic [FIELD_W-1:0] car_y_m;
    int                 last_sign_m;

    target_pt_t                pending_targets [$];
    logic signed [ANGLE_W-1:0] expected_angles [$];
    target_pt_t                next_pt;

    logic target_taken = 1'b0;
    int   gap_left     = 0;
    int   burst_left   = 0;
    int   rx_left      = 0;
    int   rx_pct       = 100;
    int   ready_pct_opts [4] = '{100, 80, 40, 8};
    logic rx_hold;
    logic rx_hold_go   = 1'b0;
    int   error_count  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // atan(1/m) in Q60 radians, alternating series
    function automatic logic [63:0] arctan_inv_q60(input logic [63:0] m);
        logic [63:0] term;
        logic [63:0] total;
        logic [63:0] d;
        logic [63:0] k;
        logic        minus;
        term  = (64'd1 << RAD_FRAC) / m;
        total = term;
        k     = 64'd1;
        minus = 1'b1;
        while (term != 64'd0)
        begin
            term  = term / m / m;
            d     = term / (2 * k + 1);
            total = minus ? total - d : total + d;
            minus = !minus;
            k     = k + 1;
        end
        return total;
    endfunction

    function automatic logic signed [63:0] toward_zero_shr(input logic signed [63:0] v,
                                                            input int s);
        logic [63:0] u;
        if (v < 0)
        begin
            u = $unsigned(-v) >> s;
            return -$signed(u);
        end
        u = $unsigned(v) >> s;
        return $signed(u);
    endfunction

    // atan(num/den) in Q56 degrees by vectoring rotations
    function automatic logic [63:0] cordic_mag_deg(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic signed [63:0] xv;
        logic signed [63:0] yv;
        logic signed [63:0] zv;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        xv = $signed(den << (SCALE_TOP - COORD_BITS_DEF));
        yv = $signed(num << (SCALE_TOP - COORD_BITS_DEF));
        zv = 64'sd0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = toward_zero_shr(xv, i);
            ys = toward_zero_shr(yv, i);
            if (yv >= 0)
            begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + $signed(micro_deg[i]);
            end
            else
            begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - $signed(micro_deg[i]);
            end
        end
        return (zv < 0) ? 64'd0 : $unsigned(zv);
    endfunction

    // expected angle for one target; updates the stored sign
    function automatic logic signed [ANGLE_W-1:0] heading_q8(input logic [FIELD_W-1:0] tx,
                                                             input logic [FIELD_W-1:0] ty);
        int          dx;
        int          dy;
        int          sgn;
        int          sh;
        logic        halve;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] nq;
        dx = int'(tx) - int'(car_x_m);
        dy = int'(car_y_m) - int'(ty);
        if (dx == 0)
        begin
            sgn = 0;
            mag = 64'd0;
        end
        else if (dy == 0)
        begin
            sgn = (dx < 0) ? -1 : 1;
            mag = 64'd50 << DEG_FRAC;
        end
        else
        begin
            sgn = ((dx < 0) != (dy < 0)) ? -1 : 1;
            mag = cordic_mag_deg(64'(dx < 0 ? -dx : dx), 64'(dy < 0 ? -dy : dy));
        end
        halve       = (sgn * last_sign_m) < 0;
        last_sign_m = sgn;
        sh          = DEG_FRAC - OUT_FRAC + (halve ? 1 : 0);
        q           = (mag + (64'd1 << (sh - 1))) >> sh;
        nq          = 64'd0 - q;
        return (sgn < 0) ? nq[ANGLE_W-1:0] : q[ANGLE_W-1:0];
    endfunction

    task automatic queue_target(input int x, input int y);
        target_pt_t pt;
        pt.x = x[FIELD_W-1:0];
        pt.y = y[FIELD_W-1:0];
        pending_targets.push_back(pt);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_targets.size() != 0 || target_ch.valid || expected_angles.size() != 0)
            @(posedge clk);
    endtask

    // target driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            target_ch.valid <= 1'b0;
        else if (target_ch.valid && !target_taken)
        begin
            // beat still waiting for ready
        end
        else if (gap_left > 0)
        begin
            target_ch.valid <= 1'b0;
            gap_left        <= gap_left - 1;
        end
        else if (pending_targets.size() > 0)
        begin
            next_pt = pending_targets.pop_front();
            target_ch.valid    <= 1'b1;
            target_ch.target_x <= next_pt.x;
            target_ch.target_y <= next_pt.y;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 24);
                case ($urandom_range(0, 4))
                    0, 1:    gap_left <= 0;
                    2, 3:    gap_left <= $urandom_range(1, 4);
                    default: gap_left <= $urandom_range(5, 70);
                endcase
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            target_ch.valid <= 1'b0;
    end

    // angle receiver: random ready, with the duty redrawn from ready_pct_opts when rx_left runs out
    always @(negedge clk)
    begin
        if (!rst_n)
            angle_ch.ready <= 1'b0;
        else
        begin
            if (rx_hold)
                angle_ch.ready <= 1'b0;
            else
                angle_ch.ready <= ($urandom_range(0, 99) < rx_pct);
            if (rx_left == 0)
            begin
                rx_left <= $urandom_range(50, 400);
                rx_pct  <= ready_pct_opts[$urandom_range(0, 3)];
            end
            else
                rx_left <= rx_left - 1;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        rx_hold = 1'b0;
        wait (rx_hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // monitor: register writes, result check, then prediction for accepted targets
    always @(posedge clk)
    begin
        if (!rst_n)
            target_taken <= 1'b0;
        else
        begin
            target_taken <= target_ch.valid && target_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_CAR_X: car_x_m = cfg_ch.data;
                    REG_CAR_Y: car_y_m = cfg_ch.data;
                    default:   ;
                endcase
            end
            if (angle_ch.valid && angle_ch.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    error_count++;
                    if (error_count < 40)
                        $display("%0t: angle_q8 beat %0d with nothing pending",
                                 $time, angle_ch.angle_q8);
                end
                else if (expected_angles[0] !== angle_ch.angle_q8)
                begin
                    error_count++;
                    if (error_count < 40)
                        $display("%0t: angle_q8 expected %0d, got %0d",
                                 $time, expected_angles[0], angle_ch.angle_q8);
                    void'(expected_angles.pop_front());
                end
                else
                    void'(expected_angles.pop_front());
            end
            if (target_ch.valid && target_ch.ready)
                expected_angles.push_back(heading_q8(target_ch.target_x, target_ch.target_y));
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [63:0]        quarter_pi;
        logic [63:0]        deg45;
        logic [127:0]       prod;
        logic [127:0]       quot;
        logic [FIELD_W-1:0] phase_x [NUM_PHASES];
        logic [FIELD_W-1:0] phase_y [NUM_PHASES];
        int                 cx;
        int                 cy;
        int                 nx;
        int                 ny;

        rst_n              = 1'b0;
        target_ch.valid    = 1'b0;
        target_ch.target_x = '0;
        target_ch.target_y = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_CAR_X;
        cfg_ch.data        = '0;
        car_x_m            = CAR_X_RST;
        car_y_m            = CAR_Y_RST;
        last_sign_m        = 0;

        // micro-angle table, Machin's formula for the degree scale
        quarter_pi   = 4 * arctan_inv_q60(64'd5) - arctan_inv_q60(64'd239);
        deg45        = 64'd45 << DEG_FRAC;
        micro_deg[0] = deg45;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            prod         = {64'd0, arctan_inv_q60(64'd1 << i)} * {64'd0, deg45};
            quot         = prod / {64'd0, quarter_pi};
            micro_deg[i] = quot[63:0];
        end

        phase_x[0] = CAR_X_RST;
        phase_y[0] = CAR_Y_RST;
        phase_x[1] = 10'd0;
        phase_y[1] = 10'd0;
        phase_x[2] = 10'd1023;
        phase_y[2] = 10'd1023;
        phase_x[3] = 10'd0;
        phase_y[3] = 10'd1023;
        phase_x[4] = 10'd1023;
        phase_y[4] = 10'd0;
        phase_x[5] = 10'd512;
        phase_y[5] = 10'd512;
        for (int p = 6; p < NUM_PHASES; p++)
        begin
            phase_x[p] = FIELD_W'($urandom_range(0, 1023));
            phase_y[p] = FIELD_W'($urandom_range(0, 1023));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                // writes to unused indexes must leave the car position alone
                write_reg(p[0] ? REG_UNUSED_A : REG_UNUSED_B,
                          FIELD_W'($urandom_range(0, 1023)));
                write_reg(REG_CAR_X, phase_x[p]);
                write_reg(REG_CAR_Y, phase_y[p]);
            end
            @(posedge clk);
            cx = int'(phase_x[p]);
            cy = int'(phase_y[p]);

            if (p == 0)
            begin
                // on column, on row both sides, sign flips, corners, next to the car
                queue_target(160, 5);
                queue_target(1023, 239);
                queue_target(0, 239);
                queue_target(0, 0);
                queue_target(1023, 0);
                queue_target(1023, 1023);
                queue_target(0, 1023);
                queue_target(161, 238);
                queue_target(159, 238);
                queue_target(160, 239);
                queue_target(161, 239);
                queue_target(159, 1023);
                queue_target(1023, 238);
                queue_target(161, 0);
                queue_target(0, 240);
                queue_target(160, 1023);
                queue_target(500, 239);
            end
            queue_target(0, 0);
            queue_target(1023, 1023);
            queue_target(0, 1023);
            queue_target(1023, 0);
            queue_target(cx, cy);

            repeat (RANDOM_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    6: queue_target(cx, $urandom_range(0, 1023));
                    7: queue_target($urandom_range(0, 1023), cy);
                    8:
                    begin
                        nx = cx + $urandom_range(0, 6) - 3;
                        ny = cy + $urandom_range(0, 6) - 3;
                        nx = (nx < 0) ? 0 : (nx > 1023) ? 1023 : nx;
                        ny = (ny < 0) ? 0 : (ny > 1023) ? 1023 : ny;
                        queue_target(nx, ny);
                    end
                    9: queue_target($urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023);
                    default: queue_target($urandom_range(0, 1023), $urandom_range(0, 1023));
                endcase
            end

            if (p == 2)
                rx_hold_go = 1'b1;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
